FILE: rtl/lmrc_pkg.sv
`default_nettype none
package lmrc_pkg;

  localparam int unsigned MaxResults = 8;
  localparam int unsigned LaneShift = 32;

  typedef enum logic [1:0] {
    ACT_REQUEST  = 2'd0,
    ACT_RESPONSE = 2'd1,
    ACT_TICK     = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_STATUS   = 2'd0,
    KIND_SEND     = 2'd1,
    KIND_RESPONSE = 2'd2
  } kind_t;

  // Datapath commands issued by the controller, one per cycle.
  typedef struct packed {
    logic capture;    // latch input beat, store request slot when lane valid and free
    logic emit_send;  // emit a send for the scan lane
    logic emit_resp;  // emit a response for the scan lane
    logic emit_stat;  // emit the status item
    logic stat_busy;  // status value
    logic mark_queue; // mark the requesting lane queued
    logic clr_queue;  // clear queued mark of scan lane
    logic use_req;    // scan lane is the request or response lane
    logic scan_load;  // reset scan pointer to zero
    logic scan_step;  // advance scan pointer
    logic last;       // this item ends the beat
  } cmd_t;

  typedef struct packed {
    logic lane_ok;    // lane within range
    logic req_busy;   // request lane out of range or its slot is busy
    logic piggy;      // read matches another busy read
    logic scan_done;  // scan pointer past last lane
    logic scan_hit;   // scan lane qualifies for the current action
    logic more_hit;   // a later lane also qualifies
    logic in_read;    // latched read flag
  } stat_t;

endpackage
`default_nettype wire

FILE: rtl/lmrc_datapath.sv
`default_nettype none
module lmrc_datapath #(
  parameter int unsigned LANES = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [63:0]         cfg_data,
  input  wire logic [1:0]          action,
  input  wire logic [2:0]          lane,
  input  wire logic                is_read,
  input  wire logic [63:0]         address,
  input  wire logic [63:0]         byte_mask,
  input  wire logic [31:0]         return_tag,
  input  wire logic [63:0]         payload,
  input  wire lmrc_pkg::cmd_t      cmd,
  output lmrc_pkg::stat_t          stat,
  output logic                     done,
  output logic [1:0]               kind,
  output logic [2:0]               dest_lane,
  output logic                     out_is_read,
  output logic [63:0]              out_address,
  output logic [63:0]              out_mask,
  output logic [63:0]              sender_id,
  output logic [63:0]              out_payload,
  output logic                     status,
  output logic                     last
);
  localparam int unsigned LW = (LANES > 1) ? $clog2(LANES) : 1;

  logic [63:0] port_id;
  logic [LANES-1:0] busy, queued;
  logic [LANES-1:0] s_rd;
  logic [63:0] s_addr [LANES];
  logic [63:0] s_mask [LANES];
  logic [31:0] s_tag  [LANES];
  logic [63:0] s_data [LANES];

  logic [1:0]  r_act;
  logic [2:0]  r_lane;
  logic        r_rd;
  logic        r_refuse;
  logic [63:0] r_addr, r_data;
  logic [LW:0] scan;

  logic [LW-1:0] req_idx, sel;
  logic [LANES-1:0] match, hit;
  logic          ok_in;

  assign ok_in   = 6'(lane) < 6'(LANES);
  assign req_idx = LW'(r_lane);
  assign sel     = cmd.use_req ? req_idx : scan[LW-1:0];

  // The responding lane itself is never part of its own broadcast.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      match[i] = busy[i] && s_rd[i] && (s_addr[i] == r_addr);
      if (r_act == lmrc_pkg::ACT_TICK) begin
        hit[i] = queued[i];
      end else begin
        hit[i] = match[i] && (LW'(i) != req_idx);
      end
    end
  end

  always_comb begin
    stat.lane_ok   = 6'(r_lane) < 6'(LANES);
    stat.req_busy  = r_refuse;
    stat.in_read   = r_rd;
    stat.piggy     = r_rd && ((match & ~(LANES'(1) << req_idx)) != '0);
    stat.scan_done = scan >= (LW+1)'(LANES);
    stat.scan_hit  = stat.scan_done ? 1'b0 : hit[scan[LW-1:0]];
    stat.more_hit  = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      if ((LW+1)'(i) > scan) begin
        stat.more_hit = stat.more_hit | hit[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      port_id <= '0;
      busy    <= '0;
      queued  <= '0;
      done    <= 1'b0;
      scan    <= '0;
    end else begin
      done <= cmd.emit_send | cmd.emit_resp | cmd.emit_stat;
      if (cfg_we) begin
        port_id <= cfg_data;
      end
      if (cmd.capture) begin
        r_act    <= action;
        r_lane   <= lane;
        r_rd     <= is_read;
        r_addr   <= address;
        r_data   <= payload;
        r_refuse <= !(ok_in && !busy[LW'(lane)]);
        if (action == lmrc_pkg::ACT_REQUEST && ok_in && !busy[LW'(lane)]) begin
          busy[LW'(lane)]   <= 1'b1;
          queued[LW'(lane)] <= 1'b0;
          s_rd[LW'(lane)]   <= is_read;
          s_addr[LW'(lane)] <= address;
          s_mask[LW'(lane)] <= byte_mask;
          s_tag[LW'(lane)]  <= return_tag;
          s_data[LW'(lane)] <= payload;
        end
      end
      if (cmd.mark_queue) begin
        queued[req_idx] <= 1'b1;
      end
      if (cmd.clr_queue) begin
        queued[sel] <= 1'b0;
      end
      if (cmd.emit_resp) begin
        busy[sel] <= 1'b0;
      end
      if (cmd.scan_load) begin
        scan <= '0;
      end else if (cmd.scan_step) begin
        scan <= scan + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_is_read <= 1'b0;
    out_address <= '0;
    out_mask    <= '0;
    sender_id   <= '0;
    out_payload <= '0;
    status      <= 1'b0;
    last        <= cmd.last;
    dest_lane   <= 3'(sel);
    kind        <= lmrc_pkg::KIND_STATUS;
    if (cmd.emit_send) begin
      kind        <= lmrc_pkg::KIND_SEND;
      out_is_read <= s_rd[sel];
      out_address <= s_addr[sel];
      out_mask    <= s_rd[sel] ? '1 : s_mask[sel];
      sender_id   <= port_id | 64'(sel);
      out_payload <= s_data[sel];
    end else if (cmd.emit_resp) begin
      kind        <= lmrc_pkg::KIND_RESPONSE;
      out_is_read <= cmd.use_req ? r_rd : 1'b1;
      out_address <= r_addr;
      out_mask    <= s_mask[sel];
      sender_id   <= (64'(sel) << lmrc_pkg::LaneShift) | 64'(s_tag[sel]);
      out_payload <= r_data;
    end else if (cmd.emit_stat) begin
      dest_lane <= r_lane;
      status    <= cmd.stat_busy;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/lmrc_ctrl.sv
`default_nettype none
module lmrc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [1:0]      action,
  input  wire logic [3:0]      accept_count,
  input  wire lmrc_pkg::stat_t stat,
  output lmrc_pkg::cmd_t       cmd,
  output logic                 busy
);
  typedef enum logic [2:0] {
    S_IDLE, S_REQ, S_RESP, S_BCAST, S_TICK
  } state_t;

  state_t     state;
  logic [3:0] acc;
  logic [3:0] n;

  assign busy = state != S_IDLE;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.capture   = start;
        cmd.scan_load = start;
      end
      S_REQ: begin
        cmd.use_req   = 1'b1;
        cmd.emit_stat = 1'b1;
        cmd.last      = 1'b1;
        // Once the send has gone out, only the accepted status remains.
        if (n != 4'd0) begin
          cmd.stat_busy = 1'b0;
        end else if (!stat.lane_ok || stat.req_busy) begin
          cmd.stat_busy = 1'b1;
        end else if (!stat.piggy) begin
          if (acc != 4'd0) begin
            cmd.emit_stat = 1'b0;
            cmd.emit_send = 1'b1;
            cmd.last      = 1'b0;
          end else begin
            cmd.stat_busy  = 1'b1;
            cmd.mark_queue = 1'b1;
          end
        end
      end
      S_RESP: begin
        cmd.use_req   = 1'b1;
        cmd.emit_resp = stat.lane_ok;
        cmd.last      = !(stat.in_read && stat.scan_hit) && !(stat.in_read && stat.more_hit);
      end
      S_BCAST: begin
        cmd.scan_step = 1'b1;
        cmd.emit_resp = stat.scan_hit;
        cmd.last      = stat.scan_hit && (!stat.more_hit || n == 4'(lmrc_pkg::MaxResults - 1));
      end
      S_TICK: begin
        cmd.scan_step = 1'b1;
        cmd.emit_send = stat.scan_hit && acc != 4'd0;
        cmd.clr_queue = cmd.emit_send;
        cmd.last      = cmd.emit_send && (!stat.more_hit || acc == 4'd1
                        || n == 4'(lmrc_pkg::MaxResults - 1));
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      acc   <= '0;
      n     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          n   <= '0;
          acc <= accept_count;
          if (start) begin
            unique case (action)
              lmrc_pkg::ACT_REQUEST:  state <= S_REQ;
              lmrc_pkg::ACT_RESPONSE: state <= S_RESP;
              lmrc_pkg::ACT_TICK:     state <= S_TICK;
              default:                state <= S_IDLE;
            endcase
          end
        end
        S_REQ: begin
          if (cmd.emit_send) begin
            acc <= acc - 4'd1;
            n   <= 4'd1;
          end else begin
            state <= S_IDLE;
          end
        end
        S_RESP: begin
          n <= {3'd0, stat.lane_ok};
          state <= (cmd.last || !stat.lane_ok) ? S_IDLE : S_BCAST;
        end
        S_BCAST: begin
          if (cmd.emit_resp) begin
            n <= n + 4'd1;
          end
          if (cmd.last || stat.scan_done || (!stat.scan_hit && !stat.more_hit)) begin
            state <= S_IDLE;
          end
        end
        S_TICK: begin
          if (cmd.emit_send) begin
            acc <= acc - 4'd1;
            n   <= n + 4'd1;
          end
          if (cmd.last || stat.scan_done || acc == 4'd0
              || (!stat.scan_hit && !stat.more_hit)) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/lane_memory_request_coalescer.sv
// Channel   | Signals                                   | Handshake
// ----------+-------------------------------------------+--------------------------
// command   | action lane is_read address byte_mask ... | start high, busy low
// result    | kind dest_lane out_* sender_id status last| done strobe, one cycle
// config    | port_id_data                              | port_id_we, no wait
//
// A request beat holds busy while it issues its result items: the send, if any,
// then the status. A response beat holds busy for its own result and then
// scans the lanes one per cycle up to the last broadcast; a tick scans the
// same way up to the last accepted retry. Each result is registered and shows
// in the cycle after the cycle that issues it.
// Reset is synchronous and clears the busy and queued marks and port_id.
// The receiver cannot stall: every result is shown for exactly one cycle.
`default_nettype none
module lane_memory_request_coalescer #(
  parameter int unsigned LANES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        port_id_we,
  input  wire logic [63:0] port_id_data,
  input  wire logic [1:0]  action,
  input  wire logic [2:0]  lane,
  input  wire logic        is_read,
  input  wire logic [63:0] address,
  input  wire logic [63:0] byte_mask,
  input  wire logic [31:0] return_tag,
  input  wire logic [63:0] payload,
  input  wire logic [3:0]  accept_count,
  output logic             done,
  output logic [1:0]       kind,
  output logic [2:0]       dest_lane,
  output logic             out_is_read,
  output logic [63:0]      out_address,
  output logic [63:0]      out_mask,
  output logic [63:0]      sender_id,
  output logic [63:0]      out_payload,
  output logic             status,
  output logic             last
);
  lmrc_pkg::cmd_t  cmd;
  lmrc_pkg::stat_t stat;
  logic            ctrl_busy;

  // Busy drops while the final result is still on show, so the next beat can
  // be taken at the same edge that takes that result.
  assign busy = ctrl_busy;

  lmrc_ctrl u_ctrl (
    .clk, .rst, .start, .action, .accept_count, .stat, .cmd, .busy(ctrl_busy)
  );

  lmrc_datapath #(.LANES(LANES)) u_dp (
    .clk, .rst, .cfg_we(port_id_we), .cfg_data(port_id_data),
    .action, .lane, .is_read, .address, .byte_mask, .return_tag, .payload,
    .cmd, .stat, .done, .kind, .dest_lane, .out_is_read, .out_address,
    .out_mask, .sender_id, .out_payload, .status, .last
  );
endmodule
`default_nettype wire
